// File: rtl/pcxrle_pkg.sv
// Shared types and constants for the PCX run-length pixel decoder.
package pcxrle_pkg;

	typedef enum logic [1:0] {
		MODE_MONO   = 2'd0,
		MODE_PLANES = 2'd1,
		MODE_INDEX  = 2'd2,
		MODE_RGB    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_PIXEL_MODE     = 2'd0,
		REG_BYTES_PER_LINE = 2'd1,
		REG_IMAGE_WIDTH    = 2'd2,
		REG_IMAGE_HEIGHT   = 2'd3
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT,
		ST_LOOK,
		ST_PUSH,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [7:0][23:0] pix;
		logic [11:0]      x;
		logic [11:0]      row;
		logic [3:0]       cnt;
		logic             last;
	} result_t;

	localparam logic [7:0]  RUN_MARK   = 8'hC0;
	localparam logic [12:0] BPL_LIMIT  = 13'd4096;
	localparam int          ROW_LIMIT  = 4096;

endpackage

// File: rtl/pcxrle_ram.sv
// Generic simple dual-port RAM with registered read.
module pcxrle_ram #(
	parameter int W  = 8,
	parameter int D  = 16,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/pcx_rle_pixel_decoder.sv
// PCX run-length pixel decoder top level.
//
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_stall   | action, data_byte, palette_index, palette_rgb
// out     | output    | out_valid / out_stall | pixel_0..7, x_start, row_index, pixel_count, last
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One transaction is taken per visit to idle; palette writes and run counts stay in idle.
// Each decoded byte passes the start step and then, as its mode needs, the wait, look and push
// steps, with one palette RAM read per output pixel (up to 8) outside RGB mode; a run repeats them.
// Palette reads go through the single read port of the palette RAM, one pixel a cycle.
// Reset clears positions and run state; line buffers and palette hold garbage until written.
// A stalled output holds the pipeline at the push and flush steps only.
module pcx_rle_pixel_decoder #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  palette_index,
	input  logic [23:0] palette_rgb,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [23:0] pixel_0,
	output logic [23:0] pixel_1,
	output logic [23:0] pixel_2,
	output logic [23:0] pixel_3,
	output logic [23:0] pixel_4,
	output logic [23:0] pixel_5,
	output logic [23:0] pixel_6,
	output logic [23:0] pixel_7,
	output logic [11:0] x_start,
	output logic [11:0] row_index,
	output logic [3:0]  pixel_count,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	import pcxrle_pkg::*;

	localparam int ROW_DEPTH = (MAX_WIDTH + 7) / 8;
	localparam int RAW       = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
	localparam int LAW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int H_LIM     = (MAX_HEIGHT < ROW_LIMIT) ? MAX_HEIGHT : ROW_LIMIT;

	state_t state_q, state_d;

	logic [1:0]  mode_q;
	logic [12:0] bpl_q, wid_q, hgt_q;
	logic        run_pend_q;
	logic [5:0]  run_len_q;
	logic [11:0] pos_q;
	logic [1:0]  plane_q;
	logic [11:0] row_q;
	logic        done_q;
	logic [7:0]  v_q;
	logic [5:0]  reps_q;
	logic [7:0][7:0]  idx_q;
	logic [3:0]  cnt_q;
	logic [11:0] x0_q;
	logic [7:0][23:0] px_q;
	logic [3:0]  iss_q;
	logic        look_pend_s1;
	logic [2:0]  look_j_s1;
	result_t     hold_q, out_q;
	logic        hold_v_q, out_v_q;

	logic [12:0] ebpl, ew, eh;
	logic        bitmode;
	logic [15:0] x0_16, rem16;
	logic        has_px;
	logic [3:0]  cnt_c;
	logic        pos_more, plane_more, row_more;
	logic        do_adv, byte_end, move, move_last, out_free;
	logic        acc_in;
	logic [5:0]  reps_c;

	logic        pal_we;
	logic [23:0] pal_rd;
	logic        prow_we;
	logic [31:0] prow_rd, prow_wd;
	logic        red_we, grn_we;
	logic [7:0]  red_rd, grn_rd;
	logic [31:0] pos_ext;
	logic [RAW-1:0] prow_addr;
	logic [LAW-1:0] line_addr;
	logic [7:0][3:0] nib_new;
	logic [7:0][3:0] nib_old;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign acc_in    = in_valid && !in_stall;
	assign out_free  = !out_v_q || !out_stall;

	assign ebpl = (bpl_q == 13'd0) ? 13'd1 : ((bpl_q > BPL_LIMIT) ? BPL_LIMIT : bpl_q);
	assign ew   = (32'(wid_q) > MAX_WIDTH) ? 13'(MAX_WIDTH) : wid_q;
	assign eh   = (hgt_q == 13'd0) ? 13'd1 : ((32'(hgt_q) > H_LIM) ? 13'(H_LIM) : hgt_q);

	assign bitmode = (mode_q == MODE_MONO) || (mode_q == MODE_PLANES);
	assign x0_16   = {1'b0, pos_q, 3'b000};
	assign rem16   = {3'b000, ew} - x0_16;

	always_comb begin
		if (bitmode) begin
			has_px = x0_16 < {3'b000, ew};
			cnt_c  = has_px ? ((rem16 >= 16'd8) ? 4'd8 : rem16[3:0]) : 4'd0;
		end else begin
			has_px = {1'b0, pos_q} < ew;
			cnt_c  = has_px ? 4'd1 : 4'd0;
		end
	end

	assign pos_more   = ({1'b0, pos_q} + 13'd1) < ebpl;
	assign plane_more = ((mode_q == MODE_PLANES) && (plane_q != 2'd3))
		|| ((mode_q == MODE_RGB) && (plane_q < 2'd2));
	assign row_more   = ({1'b0, row_q} + 13'd1) < eh;

	assign reps_c = run_pend_q ? run_len_q : 6'd1;

	assign pos_ext   = 32'(pos_q);
	assign prow_addr = pos_ext[RAW-1:0];
	assign line_addr = pos_ext[LAW-1:0];
	assign nib_old   = prow_rd;

	always_comb begin
		for (int j = 0; j < 8; j++) begin
			if (plane_q == 2'd0) begin
				nib_new[j] = {3'b000, v_q[7-j]};
			end else begin
				nib_new[j] = nib_old[j] | (4'(v_q[7-j]) << plane_q);
			end
		end
		for (int j = 0; j < 8; j++) begin
			prow_wd[4*j +: 4] = (4'(j) < cnt_q) ? nib_new[j] : nib_old[j];
		end
	end

	always_comb begin
		state_d   = state_q;
		do_adv    = 1'b0;
		byte_end  = 1'b0;
		move      = 1'b0;
		move_last = 1'b0;
		pal_we    = 1'b0;
		prow_we   = 1'b0;
		red_we    = 1'b0;
		grn_we    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (acc_in) begin
					if (action) begin
						pal_we = 1'b1;
					end else if (!done_q && (run_pend_q || data_byte < RUN_MARK)
						&& reps_c != 6'd0) begin
						state_d = ST_START;
					end
				end
			end
			ST_START: begin
				if (done_q) begin
					state_d = ST_FLUSH;
				end else if (cnt_c == 4'd0) begin
					do_adv   = 1'b1;
					byte_end = 1'b1;
				end else begin
					case (mode_q)
						MODE_MONO, MODE_INDEX: state_d = ST_LOOK;
						MODE_PLANES: state_d = ST_WAIT;
						default: begin
							if (plane_q == 2'd0) begin
								red_we   = 1'b1;
								do_adv   = 1'b1;
								byte_end = 1'b1;
							end else if (plane_q == 2'd1) begin
								grn_we   = 1'b1;
								do_adv   = 1'b1;
								byte_end = 1'b1;
							end else begin
								state_d = ST_WAIT;
							end
						end
					endcase
				end
			end
			ST_WAIT: begin
				if (mode_q == MODE_PLANES) begin
					prow_we = 1'b1;
					if (plane_q == 2'd3) begin
						state_d = ST_LOOK;
					end else begin
						do_adv   = 1'b1;
						byte_end = 1'b1;
					end
				end else begin
					state_d = ST_PUSH;
				end
			end
			ST_LOOK: begin
				if (iss_q == cnt_q && !look_pend_s1) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (!hold_v_q || out_free) begin
					move     = hold_v_q;
					do_adv   = 1'b1;
					byte_end = 1'b1;
				end
			end
			ST_FLUSH: begin
				if (!hold_v_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					move      = 1'b1;
					move_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (byte_end) begin
			state_d = (reps_q == 6'd1) ? ST_FLUSH : ST_START;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_INDEX;
			bpl_q        <= 13'd1;
			wid_q        <= 13'd1;
			hgt_q        <= 13'd1;
			run_pend_q   <= 1'b0;
			run_len_q    <= '0;
			pos_q        <= '0;
			plane_q      <= '0;
			row_q        <= '0;
			done_q       <= 1'b0;
			reps_q       <= '0;
			iss_q        <= '0;
			look_pend_s1 <= 1'b0;
			hold_v_q     <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PIXEL_MODE:     mode_q <= cfg_data[1:0];
					REG_BYTES_PER_LINE: bpl_q  <= cfg_data;
					REG_IMAGE_WIDTH:    wid_q  <= cfg_data;
					REG_IMAGE_HEIGHT:   hgt_q  <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_IDLE && acc_in && !action && !done_q) begin
				if (!run_pend_q && data_byte >= RUN_MARK) begin
					run_pend_q <= 1'b1;
					run_len_q  <= data_byte[5:0];
				end else begin
					run_pend_q <= 1'b0;
					run_len_q  <= '0;
					reps_q     <= reps_c;
				end
			end
			if (state_q == ST_START) begin
				iss_q <= '0;
			end
			look_pend_s1 <= (state_q == ST_LOOK) && (iss_q < cnt_q);
			if (state_q == ST_LOOK && iss_q < cnt_q) begin
				iss_q <= iss_q + 4'd1;
			end
			if (do_adv) begin
				if (pos_more) begin
					pos_q <= pos_q + 12'd1;
				end else begin
					pos_q <= '0;
					if (plane_more) begin
						plane_q <= plane_q + 2'd1;
					end else begin
						plane_q <= '0;
						if (row_more) begin
							row_q <= row_q + 12'd1;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
			end
			if (byte_end) begin
				reps_q <= reps_q - 6'd1;
			end
			out_v_q <= move || (out_v_q && out_stall);
			if (move_last) begin
				hold_v_q <= 1'b0;
			end else if (state_q == ST_PUSH && byte_end) begin
				hold_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && acc_in) begin
			v_q <= data_byte;
		end
		if (state_q == ST_START) begin
			cnt_q <= cnt_c;
			x0_q  <= bitmode ? x0_16[11:0] : pos_q;
			px_q  <= '0;
			for (int j = 0; j < 8; j++) begin
				idx_q[j] <= (mode_q == MODE_MONO) ? {7'd0, v_q[7-j]} : v_q;
			end
		end
		if (state_q == ST_WAIT) begin
			if (mode_q == MODE_PLANES) begin
				for (int j = 0; j < 8; j++) begin
					idx_q[j] <= {4'd0, nib_new[j]};
				end
			end else begin
				px_q[0] <= {red_rd, grn_rd, v_q};
			end
		end
		look_j_s1 <= iss_q[2:0];
		if (look_pend_s1) begin
			px_q[look_j_s1] <= pal_rd;
		end
		if (state_q == ST_PUSH && byte_end) begin
			hold_q.pix  <= px_q;
			hold_q.x    <= x0_q;
			hold_q.row  <= row_q;
			hold_q.cnt  <= cnt_q;
			hold_q.last <= 1'b0;
		end
		if (move) begin
			out_q <= {hold_q.pix, hold_q.x, hold_q.row, hold_q.cnt, move_last};
		end
	end

	pcxrle_ram #(.W(24), .D(256)) u_palette (
		.clk   (clk),
		.we    (pal_we),
		.waddr (palette_index),
		.wdata (palette_rgb),
		.raddr (idx_q[iss_q[2:0]]),
		.rdata (pal_rd)
	);

	pcxrle_ram #(.W(32), .D(ROW_DEPTH)) u_plane_row (
		.clk   (clk),
		.we    (prow_we),
		.waddr (prow_addr),
		.wdata (prow_wd),
		.raddr (prow_addr),
		.rdata (prow_rd)
	);

	pcxrle_ram #(.W(8), .D(MAX_WIDTH)) u_red_line (
		.clk   (clk),
		.we    (red_we),
		.waddr (line_addr),
		.wdata (v_q),
		.raddr (line_addr),
		.rdata (red_rd)
	);

	pcxrle_ram #(.W(8), .D(MAX_WIDTH)) u_green_line (
		.clk   (clk),
		.we    (grn_we),
		.waddr (line_addr),
		.wdata (v_q),
		.raddr (line_addr),
		.rdata (grn_rd)
	);

	assign out_valid   = out_v_q;
	assign pixel_0     = out_q.pix[0];
	assign pixel_1     = out_q.pix[1];
	assign pixel_2     = out_q.pix[2];
	assign pixel_3     = out_q.pix[3];
	assign pixel_4     = out_q.pix[4];
	assign pixel_5     = out_q.pix[5];
	assign pixel_6     = out_q.pix[6];
	assign pixel_7     = out_q.pix[7];
	assign x_start     = out_q.x;
	assign row_index   = out_q.row;
	assign pixel_count = out_q.cnt;
	assign last        = out_q.last;

`ifndef SYNTHESIS
	a_idle_hold_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !hold_v_q)
		else $error("pending result left behind at idle");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pixel_count != 4'd0 && pixel_count <= 4'd8))
		else $error("pixel count out of range");

	a_lookup_mode: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOOK |-> mode_q != MODE_RGB)
		else $error("palette lookup in RGB mode");
`endif

endmodule

// File: test/pcx_rle_pixel_decoder_test.sv
// Testbench for the PCX run-length pixel decoder: directed and random streams.
module pcx_rle_pixel_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;
	import pcxrle_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        action = 1'b0;
	logic [7:0]  data_byte = '0;
	logic [7:0]  palette_index = '0;
	logic [23:0] palette_rgb = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [23:0] pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5, pixel_6, pixel_7;
	logic [11:0] x_start;
	logic [11:0] row_index;
	logic [3:0]  pixel_count;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [12:0] cfg_data = '0;

	pcx_rle_pixel_decoder u_dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// decoder state mirror
	mode_t       cur_mode;
	int unsigned cur_bpl, cur_width, cur_height;
	bit          run_armed;
	int unsigned run_count, byte_pos, plane_no, row_no;
	bit          image_finished;
	logic [3:0]  index_line [4096];
	logic [7:0]  red_row [4096];
	logic [7:0]  green_row [4096];
	logic [23:0] palette [256];
	bit          pal_written [256];

	result_t     pixel_groups_q [$];
	int          failures = 0;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          quiet_cycles = 0;

	function automatic int unsigned plane_total();
		return cur_mode == MODE_PLANES ? 4 : (cur_mode == MODE_RGB ? 3 : 1);
	endfunction

	function automatic int unsigned line_bytes();
		if (cur_bpl == 0) return 1;
		return cur_bpl > 4096 ? 4096 : cur_bpl;
	endfunction

	function automatic void push_group(logic [7:0][23:0] pix, int unsigned cnt, int unsigned x);
		result_t g;
		g.pix = '0;
		for (int j = 0; j < 8; j++)
			if (j < cnt) g.pix[j] = pix[j];
		g.x = x[11:0];
		g.row = row_no[11:0];
		g.cnt = cnt[3:0];
		g.last = 1'b0;
		pixel_groups_q.push_back(g);
	endfunction

	function automatic void step_position();
		if (byte_pos + 1 < line_bytes()) begin
			byte_pos++;
			return;
		end
		byte_pos = 0;
		if (plane_no + 1 < plane_total()) begin
			plane_no++;
			return;
		end
		plane_no = 0;
		if (row_no + 1 < (cur_height == 0 ? 1 : (cur_height > 4096 ? 4096 : cur_height))) begin
			row_no++;
			return;
		end
		image_finished = 1'b1;
	endfunction

	function automatic void decode_pixels(logic [7:0] v);
		int unsigned w, p, x, cnt;
		logic [7:0][23:0] pix;
		logic [3:0] idx;
		logic bit_val;
		if (image_finished) return;
		w = cur_width > 4096 ? 4096 : cur_width;
		p = byte_pos;
		pix = '0;
		cnt = 0;
		if (cur_mode == MODE_MONO || cur_mode == MODE_PLANES) begin
			for (int j = 0; j < 8; j++) begin
				x = p * 8 + j;
				bit_val = v[7 - j];
				if (x < w && cnt == j) begin
					if (cur_mode == MODE_MONO) begin
						pix[j] = palette[{7'd0, bit_val}];
					end else begin
						idx = plane_no == 0 ? {3'd0, bit_val}
							: index_line[x] | (4'(bit_val) << plane_no[1:0]);
						index_line[x] = idx;
						pix[j] = palette[{4'd0, idx}];
					end
					cnt++;
				end
			end
			if (cnt > 0 && (cur_mode == MODE_MONO || plane_no == 3))
				push_group(pix, cnt, p * 8);
		end else if (cur_mode == MODE_INDEX) begin
			if (p < w) begin
				pix[0] = palette[v];
				push_group(pix, 1, p);
			end
		end else if (p < w) begin
			if (plane_no == 0) begin
				red_row[p] = v;
			end else if (plane_no == 1) begin
				green_row[p] = v;
			end else begin
				pix[0] = {red_row[p], green_row[p], v};
				push_group(pix, 1, p);
			end
		end
		step_position();
	endfunction

	function automatic void predict_transaction(logic act, logic [7:0] v, logic [7:0] pi,
			logic [23:0] rgb);
		int unsigned reps;
		int n_prior;
		result_t g;
		if (act) begin
			palette[pi] = rgb;
			pal_written[pi] = 1'b1;
			return;
		end
		if (image_finished) return;
		if (!run_armed && v >= RUN_MARK) begin
			run_armed = 1'b1;
			run_count = v[5:0];
			return;
		end
		reps = run_armed ? run_count : 1;
		run_armed = 1'b0;
		run_count = 0;
		n_prior = pixel_groups_q.size();
		for (int k = 0; k < reps; k++)
			decode_pixels(v);
		if (pixel_groups_q.size() > n_prior) begin
			g = pixel_groups_q[pixel_groups_q.size() - 1];
			g.last = 1'b1;
			pixel_groups_q[pixel_groups_q.size() - 1] = g;
		end
	endfunction

	task automatic send_item(logic act, logic [7:0] v, logic [7:0] pi, logic [23:0] rgb);
		in_valid <= 1'b1;
		action <= act;
		data_byte <= v;
		palette_index <= pi;
		palette_rgb <= rgb;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_transaction(act, v, pi, rgb);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// keep index-mode lookups on loaded palette entries
	task automatic send_data(logic [7:0] v);
		logic [7:0] d;
		d = v;
		if (cur_mode == MODE_INDEX && (run_armed || v < RUN_MARK) && !pal_written[v])
			d = v & 8'h0F;
		send_item(1'b0, d, 8'($urandom), 24'($urandom));
	endtask

	task automatic send_run(int unsigned len, logic [7:0] v);
		send_data(RUN_MARK | 8'(len));
		send_data(v);
	endtask

	// advance to the start of a row so line buffers stay consistent across setting changes
	task automatic pad_to_row();
		int unsigned rem;
		if (run_armed) send_data(8'h00);
		while ((byte_pos != 0 || plane_no != 0) && !image_finished) begin
			rem = (plane_total() - plane_no) * line_bytes() - byte_pos;
			send_run(rem > 63 ? 63 : rem, 8'($urandom_range(8'hBF)));
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pixel_groups_q.size() > 0 || in_stall || out_valid) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t r, int unsigned value);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= 13'(value);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (r)
			REG_PIXEL_MODE: begin
				cur_mode = mode_t'(value[1:0]);
			end
			REG_BYTES_PER_LINE: begin
				cur_bpl = value & 13'h1FFF;
			end
			REG_IMAGE_WIDTH: begin
				cur_width = value & 13'h1FFF;
			end
			default: begin
				cur_height = value & 13'h1FFF;
			end
		endcase
		@(posedge clk);
	endtask

	task automatic setup_image(mode_t m, int unsigned bpl, int unsigned w);
		pad_to_row();
		drain();
		write_reg(REG_PIXEL_MODE, m);
		write_reg(REG_BYTES_PER_LINE, bpl);
		write_reg(REG_IMAGE_WIDTH, w);
	endtask

	task automatic test_palette_load();
		cur_mode = MODE_INDEX;
		cur_bpl = 1;
		cur_width = 1;
		cur_height = 1;
		write_reg(REG_IMAGE_HEIGHT, 4096);
		for (int i = 0; i < 16; i++)
			send_item(1'b1, 8'($urandom), 8'(i), i == 15 ? 24'hFFFFFF : 24'($urandom));
		send_item(1'b1, 8'hFF, 8'h00, 24'h000000);
	endtask

	task automatic test_index_mode();
		setup_image(MODE_INDEX, 4, 3);
		send_data(8'h00);
		send_data(8'hBF);
		send_run(5, 8'hFF);
		send_run(0, 8'h12);
		send_item(1'b1, 8'h00, 8'h7E, 24'h5AA5C3);
		send_run(1, 8'hC7);
		send_data(8'h7E);
		send_run(63, 8'h01);
	endtask

	task automatic test_mono_mode();
		setup_image(MODE_MONO, 2, 13);
		send_data(8'hA5);
		send_data(8'hFF);
		send_run(3, 8'h00);
		send_run(4, 8'h5A);
	endtask

	task automatic test_plane_modes();
		setup_image(MODE_PLANES, 3, 20);
		for (int i = 0; i < 12; i++) send_data(8'($urandom_range(8'hBF)));
		send_run(12, 8'hFF);
		setup_image(MODE_RGB, 2, 2);
		send_data(8'h12);
		send_data(8'h34);
		send_data(8'h56);
		send_data(8'h78);
		send_run(2, 8'hFF);
		send_run(6, 8'h00);
	endtask

	task automatic test_register_extremes();
		setup_image(MODE_INDEX, 4096, 4096);
		send_data(8'h3C);
		drain();
		write_reg(REG_BYTES_PER_LINE, 1);
		send_data(8'h3D);
		setup_image(MODE_INDEX, 0, 0);
		send_run(3, 8'h44);
		setup_image(MODE_MONO, 8191, 8191);
		send_run(2, 8'hF0);
		drain();
		write_reg(REG_BYTES_PER_LINE, 1);
		send_data(8'h0F);
		setup_image(MODE_MONO, 1, 1);
		send_data(8'h80);
	endtask

	task automatic test_random_streams();
		int unsigned sel;
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = ph == 1 || ph == 3 ? (ph == 3 ? 26 : 52) : 0;
			stall_pct = ph == 2 || ph == 3 ? (ph == 3 ? 26 : 52) : 0;
			setup_image(mode_t'($urandom_range(3)), $urandom_range(1, 6), $urandom_range(1, 50));
			for (int i = 0; i < 6; i++) begin
				sel = $urandom_range(99);
				if (sel < 45)
					send_data(8'($urandom_range(8'hBF)));
				else if (sel < 80)
					send_run($urandom_range(63), 8'($urandom));
				else if (sel < 90)
					send_item(1'b1, 8'($urandom), 8'($urandom), 24'($urandom));
				else
					send_data(8'($urandom));
			end
		end
		idle_pct = 0;
		stall_pct = 0;
	endtask

	task automatic test_image_end();
		setup_image(MODE_INDEX, 2, 2);
		write_reg(REG_IMAGE_HEIGHT, 1);
		send_data(8'h05);
		send_data(8'h06);
		send_data(8'h07);
		send_run(9, 8'h08);
	endtask

	always @(posedge clk)
		out_stall <= $urandom_range(99) < stall_pct;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_t exp_g;
		logic [7:0][23:0] got_pix;
		got_pix = {pixel_7, pixel_6, pixel_5, pixel_4, pixel_3, pixel_2, pixel_1, pixel_0};
		if (arst_n && out_valid && !out_stall) begin
			if (pixel_groups_q.size() == 0) begin
				$error("unexpected pixel group transaction");
				failures++;
			end else begin
				exp_g = pixel_groups_q.pop_front();
				for (int j = 0; j < 8; j++)
					if (got_pix[j] !== exp_g.pix[j]) begin
						$error("pixel_%0d expected %h got %h", j, exp_g.pix[j], got_pix[j]);
						failures++;
					end
				if (x_start !== exp_g.x) begin
					$error("x_start expected %0d got %0d", exp_g.x, x_start);
					failures++;
				end
				if (row_index !== exp_g.row) begin
					$error("row_index expected %0d got %0d", exp_g.row, row_index);
					failures++;
				end
				if (pixel_count !== exp_g.cnt) begin
					$error("pixel_count expected %0d got %0d", exp_g.cnt, pixel_count);
					failures++;
				end
				if (last !== exp_g.last) begin
					$error("last expected %0d got %0d", exp_g.last, last);
					failures++;
				end
			end
		end
	end

	initial begin
		run_armed = 1'b0;
		run_count = 0;
		byte_pos = 0;
		plane_no = 0;
		row_no = 0;
		image_finished = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_palette_load();
		test_index_mode();
		test_mono_mode();
		test_plane_modes();
		test_register_extremes();
		test_random_streams();
		test_image_end();
		drain();
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
